/* hdl/pidc_pkg.sv */
// Shared types, constants and arithmetic helpers for the PID step block.
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int MUL_A_W   = 41;
  localparam int PROD_W    = 66;
  localparam int T_W       = 40;
  localparam int DIFF_W    = 33;
  localparam int NUM_W     = 56;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_ITER = DIV_CNT_W'(NUM_W / 2);

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd4;

  localparam logic [DT_W-1:0] DT_RESET = 16'hFFFF;

  localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [DATA_W-1:0] OUT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_T,
    ST_INTEG,
    ST_DIV_WAIT,
    ST_FIN_D,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_T
  } mul_sel_t;

  typedef struct packed {
    logic     load_err;
    logic     take_diff;
    mul_sel_t mul_sel;
    logic     take_p;
    logic     take_t;
    logic     div_start;
    logic     take_int;
    logic     take_d;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_full;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) begin
      r = OUT_MAX;
    end else if (v < S32_MIN) begin
      r = OUT_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [DT_W:0] div_step(input logic [DT_W-1:0] rem,
                                             input logic            din,
                                             input logic [DT_W-1:0] dv);
    logic [DT_W:0] sh;
    logic [DT_W:0] r;
    sh = {rem, din};
    if (sh >= {1'b0, dv}) begin
      sh = sh - {1'b0, dv};
      r  = {1'b1, sh[DT_W-1:0]};
    end else begin
      r  = {1'b0, sh[DT_W-1:0]};
    end
    return r;
  endfunction

endpackage

/* hdl/pidc_div.sv */
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module pidc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pidc_pkg::NUM_W-1:0] dividend,
  input  logic [pidc_pkg::DT_W-1:0]  divisor,
  output logic                    busy,
  output logic [pidc_pkg::NUM_W-1:0] quotient
);
  import pidc_pkg::*;

  logic [NUM_W-1:0]     acc_r;
  logic [DT_W-1:0]      rem_r;
  logic [DT_W-1:0]      dv_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DT_W:0]        step1;
  logic [DT_W:0]        step2;

  assign step1 = div_step(rem_r, acc_r[NUM_W-1], dv_r);
  assign step2 = div_step(step1[DT_W-1:0], acc_r[NUM_W-2], dv_r);

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[NUM_W-3:0], step1[DT_W], step2[DT_W]};
      rem_r <= step2[DT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_ITER;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = acc_r;

endmodule

/* hdl/pidc_ctrl.sv */
// Sequencer for one PID step: multiplier schedule, divider wait, result hand-off.
module pidc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pidc_pkg::dp_status_t status,
  output pidc_pkg::dp_cmd_t    cmd
);
  import pidc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_P;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_err = 1'b1;
          state_nxt    = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_sel   = MUL_P;
        cmd.take_diff = 1'b1;
        state_nxt     = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_sel = MUL_I;
        cmd.take_p  = 1'b1;
        state_nxt   = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_sel = MUL_D;
        cmd.take_t  = 1'b1;
        state_nxt   = ST_MUL_T;
      end
      ST_MUL_T: begin
        // product register holds the derivative numerator here
        cmd.mul_sel   = MUL_T;
        cmd.div_start = 1'b1;
        state_nxt     = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.take_int = 1'b1;
        state_nxt    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = ST_FIN_D;
        end
      end
      ST_FIN_D: begin
        cmd.take_d = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pidc_dp.sv */
// PID datapath: settings, state, shared multiplier, divider and output register.
module pidc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pidc_pkg::dp_cmd_t                 cmd,
  output pidc_pkg::dp_status_t              status,
  input  logic signed [pidc_pkg::DATA_W-1:0] in_measured_value,
  input  logic                              cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]       cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [pidc_pkg::DATA_W-1:0] out_control_output,
  output logic signed [pidc_pkg::DATA_W-1:0] out_error_value,
  output logic signed [pidc_pkg::DATA_W-1:0] out_p_term,
  output logic signed [pidc_pkg::DATA_W-1:0] out_i_term,
  output logic signed [pidc_pkg::DATA_W-1:0] out_d_term
);
  import pidc_pkg::*;

  logic [GAIN_W-1:0]        p_gain_r;
  logic [GAIN_W-1:0]        i_gain_r;
  logic [GAIN_W-1:0]        d_gain_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [DATA_W-1:0] setpoint_r;

  logic signed [DATA_W-1:0] integ_r;
  logic signed [DATA_W-1:0] last_r;

  logic signed [DATA_W-1:0] err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DATA_W-1:0] p_r;
  logic signed [T_W-1:0]    t_r;
  logic signed [DATA_W-1:0] d_r;
  logic                     num_neg_r;
  logic                     num_zero_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_shr;
  logic signed [PROD_W-1:0]  num_mag;
  logic signed [PROD_W-1:0]  quot_ext;
  logic [NUM_W-1:0]          quot;
  logic                      div_busy;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_ctrl_r;
  logic signed [DATA_W-1:0] out_err_r;
  logic signed [DATA_W-1:0] out_p_r;
  logic signed [DATA_W-1:0] out_i_r;
  logic signed [DATA_W-1:0] out_d_r;

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r   <= '0;
      i_gain_r   <= '0;
      d_gain_r   <= '0;
      dt_r       <= DT_RESET;
      setpoint_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_GAIN:        p_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN:        i_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:        d_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: dt_r       <= cfg_data[DT_W-1:0];
        REG_SETPOINT:      setpoint_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier, registered
  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = p_gain_r;
      end
      MUL_I: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = i_gain_r;
      end
      MUL_D: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = d_gain_r;
      end
      MUL_T: begin
        mul_a = MUL_A_W'(t_r);
        mul_b = GAIN_W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
  assign prod_shr = prod_r >>> FRAC_W;  // floor
  assign num_mag  = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign quot_ext = PROD_W'(quot);

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_mag[NUM_W-1:0]),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
    end else if (cmd.take_int) begin
      integ_r <= sat32(PROD_W'(integ_r) + prod_shr);
      last_r  <= err_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_err) begin
      err_r <= sat32(PROD_W'(setpoint_r) - PROD_W'(in_measured_value));
    end
    if (cmd.take_diff) begin
      diff_r <= DIFF_W'(err_r) - DIFF_W'(last_r);
    end
    if (cmd.take_p) begin
      p_r <= sat32(prod_shr);
    end
    if (cmd.take_t) begin
      t_r <= prod_shr[T_W-1:0];
    end
    if (cmd.div_start) begin
      num_neg_r  <= prod_r[PROD_W-1];
      num_zero_r <= (prod_r == '0);
    end
    if (cmd.take_d) begin
      if (dt_r == '0) begin
        // zero period: saturate toward the numerator's sign
        if (num_zero_r) begin
          d_r <= '0;
        end else if (num_neg_r) begin
          d_r <= OUT_MIN;
        end else begin
          d_r <= OUT_MAX;
        end
      end else begin
        d_r <= sat32(num_neg_r ? -quot_ext : quot_ext);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ctrl_r <= sat32(PROD_W'(p_r) + PROD_W'(integ_r) + PROD_W'(d_r));
      out_err_r  <= err_r;
      out_p_r    <= p_r;
      out_i_r    <= integ_r;
      out_d_r    <= d_r;
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_full = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_control_output = out_ctrl_r;
  assign out_error_value    = out_err_r;
  assign out_p_term         = out_p_r;
  assign out_i_term         = out_i_r;
  assign out_d_term         = out_d_r;

endmodule

/* hdl/pid_controller_step_top.sv */
// Top level of the fixed-point PID step block.
//
// Input channel: in_valid / in_stall carry one measured sample word (signed
// Q15.16). Result channel: out_valid / out_stall carry the control output,
// the error and the P, I and D terms. A word moves when valid is high and
// stall is low.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; writes
// are taken every cycle and should be issued only while the block is idle.
// Unknown indexes are dropped.
// One sample goes from accept to result through four products on the shared
// multiplier, then the radix-4 divider for the derivative (56-bit numerator,
// two bits per cycle), then the steps that finish the derivative and load the
// output register. One sample is in work at a time: in_stall rises after
// accept and falls when the result enters the output register.
// The output register holds a finished word while out_stall is high; the next
// sample is worked on meanwhile and waits only if that register is still full.
// Reset clears the gains, setpoint, integral and last error and sets the
// sample period to its maximum.
module pid_controller_step_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pidc_pkg::DATA_W-1:0] in_measured_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pidc_pkg::DATA_W-1:0] out_control_output,
  output logic signed [pidc_pkg::DATA_W-1:0] out_error_value,
  output logic signed [pidc_pkg::DATA_W-1:0] out_p_term,
  output logic signed [pidc_pkg::DATA_W-1:0] out_i_term,
  output logic signed [pidc_pkg::DATA_W-1:0] out_d_term,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data
);
  import pidc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pidc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_measured_value  (in_measured_value),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_control_output (out_control_output),
    .out_error_value    (out_error_value),
    .out_p_term         (out_p_term),
    .out_i_term         (out_i_term),
    .out_d_term         (out_d_term)
  );

endmodule

/* dv/tb_pid_controller_step_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-point PID step block, with its own step predictor.
module tb_pid_controller_step_top;
  import pidc_pkg::*;

  localparam int IDLE_PCT      = 15;
  localparam int LATENCY       = 40;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int LONG_STRETCH  = 150;
  localparam int RANDOM_ITEMS  = 830;
  localparam int MAX_REPORTS   = 25;
  localparam int SP_SPREAD     = 1 << 20;
  localparam int MEAS_SPREAD   = 1 << 18;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_SETPOINT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [DATA_W-1:0] ctl_out;
    logic [DATA_W-1:0] err_val;
    logic [DATA_W-1:0] p_term;
    logic [DATA_W-1:0] i_term;
    logic [DATA_W-1:0] d_term;
  } pid_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TYPED,
    ROW_PREDICTED
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DATA_W-1:0]     data;
    pid_result_t           want;
  } stim_row_t;

  localparam pid_result_t NO_RESULT = '0;
  localparam int NUM_DIRECTED = 34;

  // typed rows: gains at zero or at full scale, so only the error, the
  // saturated proportional term and the control output can be nonzero
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_TYPED,     '0,                32'h0000_0000, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{ROW_TYPED,     '0,                OUT_MIN,       '{32'h0, OUT_MAX, 32'h0, 32'h0, 32'h0}},
    '{ROW_TYPED,     '0,                OUT_MAX,
      '{32'h0, 32'h8000_0001, 32'h0, 32'h0, 32'h0}},
    '{ROW_CFG,       REG_P_GAIN,        32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,       REG_SETPOINT,      OUT_MAX,       NO_RESULT},
    '{ROW_TYPED,     '0,                OUT_MIN,       '{OUT_MAX, OUT_MAX, OUT_MAX, 32'h0, 32'h0}},
    '{ROW_TYPED,     '0,                OUT_MAX,       '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{ROW_CFG,       REG_SETPOINT,      OUT_MIN,       NO_RESULT},
    '{ROW_TYPED,     '0,                OUT_MAX,       '{OUT_MIN, OUT_MIN, OUT_MIN, 32'h0, 32'h0}},
    '{ROW_CFG,       REG_I_GAIN,        32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,       REG_D_GAIN,        32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,       REG_SAMPLE_PERIOD, 32'hFFFF_0001, NO_RESULT},
    '{ROW_PREDICTED, '0,                OUT_MIN,       NO_RESULT},
    '{ROW_PREDICTED, '0,                OUT_MAX,       NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0000_0000, NO_RESULT},
    '{ROW_PREDICTED, '0,                OUT_MAX,       NO_RESULT},
    // zero sample period: integral frozen, derivative pinned to the sign
    '{ROW_CFG,       REG_SAMPLE_PERIOD, 32'hFFFF_0000, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0000_0001, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0000_0001, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'hFFFF_0000, NO_RESULT},
    '{ROW_PREDICTED, '0,                OUT_MAX,       NO_RESULT},
    '{ROW_CFG,       REG_SAMPLE_PERIOD, 32'h0000_FFFF, NO_RESULT},
    '{ROW_CFG,       REG_P_GAIN,        32'h0001_0000, NO_RESULT},
    '{ROW_CFG,       REG_I_GAIN,        32'h0000_8000, NO_RESULT},
    '{ROW_CFG,       REG_D_GAIN,        32'h0000_0100, NO_RESULT},
    '{ROW_CFG,       REG_SETPOINT,      32'h0001_0000, NO_RESULT},
    // writes to unmapped indexes must leave every register alone
    '{ROW_CFG,       REG_SPARE_FIRST,   32'h1234_5678, NO_RESULT},
    '{ROW_CFG,       REG_SPARE_LAST,    32'hFFFF_FFFF, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0000_0000, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0001_8000, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'hFFFF_8000, NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0001_0000, NO_RESULT},
    '{ROW_PREDICTED, '0,                OUT_MIN,       NO_RESULT},
    '{ROW_PREDICTED, '0,                32'h0000_0000, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_measured_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_control_output;
  logic [DATA_W-1:0]    out_error_value;
  logic [DATA_W-1:0]    out_p_term;
  logic [DATA_W-1:0]    out_i_term;
  logic [DATA_W-1:0]    out_d_term;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // register mirror and controller state
  longint kp_cfg = 0;
  longint ki_cfg = 0;
  longint kd_cfg = 0;
  longint dt_cfg = 65535;
  longint sp_cfg = 0;
  longint integ_acc = 0;
  longint prev_err = 0;

  pid_result_t pending_outputs [$];

  int n_errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_settings = 0;
  int n_dt_zero = 0;
  int stuck_cycles = 0;
  int hold_cycles = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  pid_controller_step_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_measured_value (in_measured_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_control_output(out_control_output),
    .out_error_value   (out_error_value),
    .out_p_term        (out_p_term),
    .out_i_term        (out_i_term),
    .out_d_term        (out_d_term),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic pid_result_t compute_pid_terms(input logic signed [DATA_W-1:0] meas);
    pid_result_t r;
    longint m;
    longint e;
    longint p;
    longint t;
    longint inc;
    longint num;
    longint d;
    m   = meas;
    e   = clamp32(sp_cfg - m);
    p   = clamp32((kp_cfg * e) >>> FRAC_W);
    t   = (ki_cfg * e) >>> FRAC_W;
    inc = (t * dt_cfg) >>> FRAC_W;
    integ_acc = clamp32(integ_acc + inc);
    // difference is kept exact, 33 bits
    num = kd_cfg * (e - prev_err);
    if (dt_cfg == 0) begin
      if (num > 0) d = OUT_MAX;
      else if (num < 0) d = OUT_MIN;
      else d = 0;
    end else begin
      d = clamp32(num / dt_cfg);
    end
    prev_err  = e;
    r.ctl_out = clamp32(p + integ_acc + d);
    r.err_val = e[DATA_W-1:0];
    r.p_term  = p[DATA_W-1:0];
    r.i_term  = integ_acc[DATA_W-1:0];
    r.d_term  = d[DATA_W-1:0];
    return r;
  endfunction

  task automatic report_fail(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) report_fail($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] meas, input bit typed,
                             input pid_result_t want);
    pid_result_t res;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_measured_value <= meas;
    do @(posedge clk); while (in_stall);
    res = compute_pid_terms(meas);
    if (typed) res = want;
    pending_outputs = {pending_outputs, res};
    n_samples++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      REG_P_GAIN:        kp_cfg = data[GAIN_W-1:0];
      REG_I_GAIN:        ki_cfg = data[GAIN_W-1:0];
      REG_D_GAIN:        kd_cfg = data[GAIN_W-1:0];
      REG_SAMPLE_PERIOD: begin
        dt_cfg = data[DT_W-1:0];
        if (dt_cfg == 0) n_dt_zero++;
      end
      REG_SETPOINT:      sp_cfg = $signed(data);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop valid and let the block drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_side
    pid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_outputs.size() == 0) begin
        report_fail("result word with nothing outstanding");
      end else begin
        want = pending_outputs.pop_front();
        check_field("control_output", out_control_output, want.ctl_out);
        check_field("error_value", out_error_value, want.err_val);
        check_field("p_term", out_p_term, want.p_term);
        check_field("i_term", out_i_term, want.i_term);
        check_field("d_term", out_d_term, want.d_term);
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_IDX_W-1:0] r;
    logic [GAIN_W-1:0]    gain;
    logic [DT_W-1:0]      dt;
    logic [DATA_W-1:0]    wdata;
    logic [DATA_W-1:0]    meas;
    int unsigned          ph;
    int unsigned          len;
    int unsigned          n_rand;
    ph     = 0;
    n_rand = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(DIRECTED[i].idx, DIRECTED[i].data);
        end
        ROW_TYPED:     send_sample(DIRECTED[i].data, 1'b1, DIRECTED[i].want);
        default:       send_sample(DIRECTED[i].data, 1'b0, NO_RESULT);
      endcase
    end

    while (n_rand < RANDOM_ITEMS) begin
      wait_idle();
      for (r = REG_P_GAIN; r <= REG_SETPOINT; r++) begin
        if (ph == 0 || $urandom_range(0, 9) < 7) begin
          case (r)
            REG_SAMPLE_PERIOD: begin
              case ($urandom_range(0, 9))
                0:       dt = '0;
                1:       dt = 16'd1;
                2:       dt = '1;
                3, 4, 5: dt = 16'($urandom());
                default: dt = 16'($urandom_range(256, 16384));
              endcase
              wdata = {16'($urandom()), dt};
            end
            REG_SETPOINT: begin
              case ($urandom_range(0, 7))
                0:       wdata = OUT_MAX;
                1:       wdata = OUT_MIN;
                2:       wdata = $urandom();
                default: wdata = 32'(int'($urandom_range(0, 2 * SP_SPREAD)) - SP_SPREAD);
              endcase
            end
            default: begin
              case ($urandom_range(0, 5))
                0:       gain = '0;
                1:       gain = '1;
                2:       gain = 24'($urandom_range(0, 24'h02_0000));
                3, 4:    gain = 24'($urandom_range(0, 24'h00_0800));
                default: gain = 24'($urandom());
              endcase
              // upper byte is junk the block must drop
              wdata = {8'($urandom()), gain};
            end
          endcase
          write_reg(r, wdata);
        end
      end
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), $urandom());
      n_settings++;

      len     = (ph == 1) ? LONG_STRETCH : $urandom_range(20, 60);
      no_idle = (ph == 1);
      // long output hold: block fills up and must stall its input
      if (ph == 3) hold_cycles = HOLD_CYCLES;
      repeat (len) begin
        case ($urandom_range(0, 9))
          0:       meas = $urandom();
          1:       meas = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
          default: meas = sp_cfg[DATA_W-1:0]
                          + 32'(int'($urandom_range(0, 2 * MEAS_SPREAD)) - MEAS_SPREAD);
        endcase
        send_sample(meas, 1'b0, NO_RESULT);
        n_rand++;
      end
      ph++;
    end

    no_idle = 1'b0;
    wait_idle();
    $display("Checked %0d result words for %0d samples, %0d mismatches.",
             n_results, n_samples, n_errors);
    $display("%0d register writes over %0d random settings, %0d with a zero sample period.",
             n_writes, n_settings, n_dt_zero);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pidc_pkg.sv
hdl/pidc_div.sv
hdl/pidc_ctrl.sv
hdl/pidc_dp.sv
hdl/pid_controller_step_top.sv
dv/tb_pid_controller_step_top.sv
